### rtl/rlsl_pkg.sv
// Package for the periodic run-length segment lookup block.
// Holds widths, codes, state machine type and the structs shared by the table, sequencer and top.
// Depends on nothing.
package rlsl_pkg;

    localparam int MaxRuns  = 1024;
    localparam int CountW   = $clog2(MaxRuns + 1);
    localparam int HintW    = $clog2(MaxRuns);
    localparam int AddrW    = $clog2(MaxRuns + 1);
    localparam int PosW     = 24;
    localparam int SegW     = 16;
    localparam int CfgW     = 24;
    localparam int CfgIdxW  = 2;
    localparam int BitCntW  = $clog2(PosW);

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_RUN_COUNT     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STREAM_LENGTH = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEARCH,
        ST_HINT,
        ST_DONE
    } rlsl_state_t;

    typedef struct packed {
        logic [CountW-1:0] run_count;
        logic [PosW-1:0]   stream_length;
        logic [PosW-1:0]   repeat_period;
    } rlsl_cfg_t;

    typedef struct packed {
        logic              we_start;
        logic              we_seg;
        logic [AddrW-1:0]  addr;
        logic [PosW-1:0]   start;
        logic [SegW-1:0]   segment;
    } rlsl_wr_t;

    typedef struct packed {
        logic [AddrW-1:0]  start_addr;
        logic [HintW-1:0]  seg_addr;
    } rlsl_rd_t;

    typedef struct packed {
        logic              found;
        logic [SegW-1:0]   segment_id;
    } rlsl_res_t;

endpackage

### rtl/rlsl_if.sv
// Handshake channels of the run-length segment lookup block.
// One interface for input items and one for result items; uses rlsl_pkg.
interface rlsl_item_if
    import rlsl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [CountW-1:0] entry_index;
    logic [PosW-1:0]   entry_start;
    logic [SegW-1:0]   entry_segment;
    logic [PosW-1:0]   position;

    modport source (output valid, action, entry_index, entry_start, entry_segment, position,
                    input ready);
    modport sink   (input valid, action, entry_index, entry_start, entry_segment, position,
                    output ready);
endinterface

interface rlsl_result_if
    import rlsl_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            found;
    logic [SegW-1:0] segment_id;

    modport source (output valid, found, segment_id, input ready);
    modport sink   (input valid, found, segment_id, output ready);
endinterface

### rtl/rlsl_mod_unit.sv
// Bit-serial remainder unit: one restoring step per cycle over the position bits.
// Depends on rlsl_pkg.
module rlsl_mod_unit
    import rlsl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PosW-1:0] dividend,
    input  logic [PosW-1:0] divisor,
    output logic            done,
    output logic [PosW-1:0] remainder
);

    logic               busy_reg;
    logic [BitCntW-1:0] cnt_reg;
    logic [PosW-1:0]    rem_reg;
    logic [PosW-1:0]    dvd_reg;
    logic [PosW-1:0]    dsr_reg;
    logic [PosW:0]      trial;
    logic [PosW-1:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[PosW-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = PosW'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[PosW-1:0];
        end
    end

    assign done      = busy_reg && (cnt_reg == BitCntW'(PosW - 1));
    assign remainder = rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[PosW-2:0], 1'b0};
        end
    end

endmodule

### rtl/rlsl_table.sv
// Run table storage: start positions with the sentinel slot, and segment ids.
// Synchronous memories with one write port and registered reads; uses rlsl_pkg.
module rlsl_table
    import rlsl_pkg::*;
(
    input  logic            clk,
    input  rlsl_wr_t        wr,
    input  rlsl_rd_t        rd,
    output logic [PosW-1:0] rd_start,
    output logic [SegW-1:0] rd_segment
);

    logic [PosW-1:0] starts_mem [MaxRuns+1];
    logic [SegW-1:0] segs_mem   [MaxRuns];

    always_ff @(posedge clk)
    begin
        if (wr.we_start)
        begin
            starts_mem[wr.addr] <= wr.start;
        end
        rd_start <= starts_mem[rd.start_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.we_seg)
        begin
            segs_mem[wr.addr[HintW-1:0]] <= wr.segment;
        end
        rd_segment <= segs_mem[rd.seg_addr];
    end

endmodule

### rtl/rlsl_seq.sv
// Query sequencer: table writes, position reduction, binary search and hint upkeep.
// Depends on rlsl_pkg, rlsl_if and the table and remainder units driven by the top.
module rlsl_seq
    import rlsl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    rlsl_item_if.sink       items,
    input  rlsl_cfg_t       cfg,
    input  logic            out_free,
    input  logic            mod_done,
    input  logic [PosW-1:0] mod_rem,
    input  logic [PosW-1:0] rd_start,
    input  logic [SegW-1:0] rd_segment,
    output logic            mod_start,
    output rlsl_wr_t        wr,
    output rlsl_rd_t        rd,
    output logic            done,
    output rlsl_res_t       res
);

    rlsl_state_t       state_reg, state_next;
    logic [PosW-1:0]   m_reg;
    logic [HintW-1:0]  lo_reg, hi_reg, mid_reg;
    logic              pend_reg;
    logic [1:0]        k_reg;
    logic [HintW-1:0]  hint_reg;
    logic [PosW-1:0]   sh_reg, sh1_reg;
    rlsl_res_t         res_reg;

    logic [CountW-1:0] count;
    logic              query;
    logic              bad;
    logic              reduce;
    logic [HintW-1:0]  lo_c, hi_c, mid_c;
    logic [HintW:0]    span;
    logic [AddrW-1:0]  h1_addr, h2_addr;
    logic              hint_hit, hint_succ;

    assign count  = (cfg.run_count > CountW'(MaxRuns)) ? CountW'(MaxRuns) : cfg.run_count;
    assign query  = items.valid && (items.action == ACT_QUERY);
    assign bad    = (count == '0) || (items.position >= cfg.stream_length);
    assign reduce = (cfg.repeat_period != '0) && (cfg.repeat_period < cfg.stream_length);

    always_comb
    begin
        lo_c = lo_reg;
        hi_c = hi_reg;
        if (pend_reg)
        begin
            if (rd_start <= m_reg)
            begin
                lo_c = mid_reg;
            end
            else
            begin
                hi_c = mid_reg - 1'b1;
            end
        end
        span  = {1'b0, hi_c} - {1'b0, lo_c} + 1'b1;
        mid_c = lo_c + span[HintW:1];
    end

    assign h1_addr   = AddrW'(hint_reg) + 1'b1;
    assign h2_addr   = (h1_addr >= AddrW'(MaxRuns)) ? AddrW'(MaxRuns) : h1_addr + 1'b1;
    assign hint_hit  = (CountW'(hint_reg) < count) && (m_reg >= sh_reg) && (m_reg < sh1_reg);
    assign hint_succ = (CountW'(h1_addr) < count) && (m_reg >= sh1_reg) && (m_reg < rd_start);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query)
                begin
                    if (bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (reduce)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!(lo_c < hi_c))
                begin
                    state_next = ST_HINT;
                end
            end
            ST_HINT:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        items.ready   = (state_reg == ST_IDLE);
        mod_start     = (state_reg == ST_IDLE) && query && !bad && reduce;
        done          = (state_reg == ST_DONE);
        res           = res_reg;
        wr.addr       = items.entry_index;
        wr.start      = items.entry_start;
        wr.segment    = items.entry_segment;
        wr.we_start   = (state_reg == ST_IDLE) && items.valid && (items.action == ACT_WRITE)
                        && (items.entry_index <= CountW'(MaxRuns));
        wr.we_seg     = wr.we_start && (items.entry_index < CountW'(MaxRuns));
        rd.seg_addr   = lo_reg;
        rd.start_addr = '0;
        if (state_reg == ST_SEARCH)
        begin
            rd.start_addr = AddrW'(mid_c);
        end
        else if (state_reg == ST_HINT)
        begin
            priority case (k_reg)
                2'd0:    rd.start_addr = AddrW'(hint_reg);
                2'd1:    rd.start_addr = h1_addr;
                default: rd.start_addr = h2_addr;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
            hint_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE, ST_MOD:
                begin
                    pend_reg <= 1'b0;
                    k_reg    <= '0;
                end
                ST_SEARCH:
                begin
                    pend_reg <= (lo_c < hi_c);
                end
                ST_HINT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3 && !hint_hit)
                    begin
                        hint_reg <= hint_succ ? h1_addr[HintW-1:0] : lo_reg;
                    end
                end
                default:
                begin
                    k_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                m_reg   <= items.position;
                lo_reg  <= '0;
                hi_reg  <= HintW'(count - 1'b1);
                res_reg <= '0;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    m_reg <= mod_rem;
                end
            end
            ST_SEARCH:
            begin
                lo_reg  <= lo_c;
                hi_reg  <= hi_c;
                mid_reg <= mid_c;
            end
            ST_HINT:
            begin
                if (k_reg == 2'd1)
                begin
                    sh_reg             <= rd_start;
                    res_reg.found      <= 1'b1;
                    res_reg.segment_id <= rd_segment;
                end
                if (k_reg == 2'd2)
                begin
                    sh1_reg <= rd_start;
                end
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
    end

endmodule

### rtl/periodic_run_length_segment_lookup_top.sv
// Top level of the periodic run-length segment lookup: configuration, output register.
// A write item is taken whenever the sequencer is idle. A query result is registered after the item:
// remainder steps when reduced, the binary search over the start table, the hint states and
// the result state; no new item is taken until the result is registered. A bad position or an
// empty table goes straight to the result state. A full output register that is not read holds it.
// Reset clears configuration, hint and handshake state; table contents are kept. Uses rlsl_*.
module periodic_run_length_segment_lookup_top
    import rlsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rlsl_item_if.sink          items,
    rlsl_result_if.source      results,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    rlsl_cfg_t       cfg_reg;
    logic            out_valid_reg;
    rlsl_res_t       out_reg;

    logic            out_free;
    logic            mod_start, mod_done;
    logic [PosW-1:0] mod_rem;
    rlsl_wr_t        wr;
    rlsl_rd_t        rd;
    logic [PosW-1:0] rd_start;
    logic [SegW-1:0] rd_segment;
    logic            seq_done;
    rlsl_res_t       seq_res;

    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RUN_COUNT:     cfg_reg.run_count     <= cfg_data[CountW-1:0];
                CFG_STREAM_LENGTH: cfg_reg.stream_length <= cfg_data[PosW-1:0];
                CFG_REPEAT_PERIOD: cfg_reg.repeat_period <= cfg_data[PosW-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done && out_free)
        begin
            out_reg <= seq_res;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.found      = out_reg.found;
    assign results.segment_id = out_reg.segment_id;

    rlsl_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (items.position),
        .divisor   (cfg_reg.repeat_period),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    rlsl_table u_table (
        .clk        (clk),
        .wr         (wr),
        .rd         (rd),
        .rd_start   (rd_start),
        .rd_segment (rd_segment)
    );

    rlsl_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg_reg),
        .out_free   (out_free),
        .mod_done   (mod_done),
        .mod_rem    (mod_rem),
        .rd_start   (rd_start),
        .rd_segment (rd_segment),
        .mod_start  (mod_start),
        .wr         (wr),
        .rd         (rd),
        .done       (seq_done),
        .res        (seq_res)
    );

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && items.action == ACT_QUERY) |=> !items.ready)
        else $error("input still ready in the cycle after a query item");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.found) |-> (results.segment_id == '0))
        else $error("not-found result carries a nonzero segment id");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(!items.ready))
        else $error("result item appeared without a query in progress");

endmodule
